// ----- rtl/u8g_pkg.sv -----
// Shared types and constants for the UTF-8 to glyph index unit.
package u8g_pkg;

	localparam int BYTE_W  = 8;
	localparam int CP_W    = 21;
	localparam int CODE_W  = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LAST_CODE  = 2'd1;

	localparam logic [CODE_W-1:0] FIRST_CODE_RST = 16'd32;
	localparam logic [CODE_W-1:0] LAST_CODE_RST  = 16'd126;

	localparam logic [CP_W-1:0] FALLBACK_CP = 21'h00003F;

	// job queue between decoder and result sequencer
	localparam int JOB_DEPTH = 4;
	localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
	localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

	typedef struct packed {
		logic [CODE_W-1:0] first_code;
		logic [CODE_W-1:0] last_code;
	} font_cfg_t;

	// one input byte's worth of results: rep_cnt replacements, then
	// optionally one decoded codepoint
	typedef struct packed {
		logic [2:0]      rep_cnt;
		logic            has_cp;
		logic [CP_W-1:0] cp;
		logic            text_end;
	} job_t;

endpackage

// ----- rtl/utf8_to_glyph_index_unit.sv -----
// Top level of the UTF-8 to glyph index unit.
// Takes one string byte per cycle whenever full is low and turns it into 0 to 4 results
// (codepoint, replacement flag, glyph index). The decoder turns each byte that yields
// results into one job in the cycle it is accepted; a 4-entry job queue feeds the result
// sequencer, which delivers one result per cycle from its output register while pop is
// high. A byte causing n results therefore occupies the sequencer for all n results; most
// bytes cause at most one, so the sustained rate is one byte per cycle, with the queue
// absorbing bursts of flushed replacements. A byte's first result passes through the job
// queue and then the output register. Configuration writes are always ready and registered.
module utf8_to_glyph_index_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [u8g_pkg::BYTE_W-1:0]    byte_value,
	input  logic                          string_end,
	output logic                          empty,
	input  logic                          pop,
	output logic [u8g_pkg::CP_W-1:0]      code_point,
	output logic                          is_replacement,
	output logic [u8g_pkg::CODE_W-1:0]    glyph_index,
	output logic                          has_glyph,
	output logic                          run_last,
	output logic                          text_last,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [u8g_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [u8g_pkg::CODE_W-1:0]    cfg_data
);

	u8g_pkg::font_cfg_t cfg_q;
	logic               accept;
	logic               fe_job_valid;
	u8g_pkg::job_t      fe_job;
	logic               q_full;
	logic               q_not_empty;
	u8g_pkg::job_t      q_job;
	logic               q_pop;

	assign cfg_ready = 1'b1;
	assign full      = q_full;
	assign accept    = push && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_code <= u8g_pkg::FIRST_CODE_RST;
			cfg_q.last_code  <= u8g_pkg::LAST_CODE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				u8g_pkg::CFG_FIRST_CODE: cfg_q.first_code <= cfg_data;
				u8g_pkg::CFG_LAST_CODE:  cfg_q.last_code  <= cfg_data;
				default: ;
			endcase
		end
	end

	u8g_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.byte_value (byte_value),
		.string_end (string_end),
		.job_valid  (fe_job_valid),
		.job        (fe_job)
	);

	u8g_job_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (fe_job_valid),
		.wr_job    (fe_job),
		.full      (q_full),
		.rd_en     (q_pop),
		.rd_job    (q_job),
		.not_empty (q_not_empty)
	);

	u8g_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.job_valid      (q_not_empty),
		.job            (q_job),
		.job_pop        (q_pop),
		.pop            (pop),
		.empty          (empty),
		.code_point     (code_point),
		.is_replacement (is_replacement),
		.glyph_index    (glyph_index),
		.has_glyph      (has_glyph),
		.run_last       (run_last),
		.text_last      (text_last)
	);

endmodule

// ----- rtl/u8g_front.sv -----
// Decoder front end: buffers multi-byte sequences and emits one job per byte that yields results.
module u8g_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [u8g_pkg::BYTE_W-1:0] byte_value,
	input  logic                       string_end,
	output logic                       job_valid,
	output u8g_pkg::job_t              job
);

	logic [u8g_pkg::BYTE_W-1:0] pend_q [3];
	logic [1:0]                 pcnt_q;
	logic [2:0]                 slen_q;

	logic [u8g_pkg::BYTE_W-1:0] pend_n [3];
	logic [1:0]                 pcnt_n;
	logic [2:0]                 slen_n;
	logic [2:0]                 rep;
	logic                       has_cp;
	logic [u8g_pkg::CP_W-1:0]   cp;
	logic                       start;
	logic                       is_cont;
	logic [2:0]                 lead_len;
	logic [7:0]                 lead_m;
	logic [25:0]                acc;

	always_comb begin
		if (byte_value[7:5] == 3'b110) begin
			lead_len = 3'd2;
		end else if (byte_value[7:4] == 4'b1110) begin
			lead_len = 3'd3;
		end else if (byte_value[7:3] == 5'b11110) begin
			lead_len = 3'd4;
		end else begin
			lead_len = 3'd0;
		end
	end

	always_comb begin
		case (slen_q)
			3'd2:    lead_m = pend_q[0] & 8'h1F;
			3'd3:    lead_m = pend_q[0] & 8'h0F;
			default: lead_m = pend_q[0] & 8'h07;
		endcase
		case (pcnt_q)
			2'd1:    acc = {12'b0, lead_m, byte_value[5:0]};
			2'd2:    acc = {6'b0, lead_m, pend_q[1][5:0], byte_value[5:0]};
			default: acc = {lead_m, pend_q[1][5:0], pend_q[2][5:0], byte_value[5:0]};
		endcase
	end

	always_comb begin
		rep     = 3'd0;
		has_cp  = 1'b0;
		cp      = '0;
		pend_n  = pend_q;
		pcnt_n  = pcnt_q;
		slen_n  = slen_q;
		start   = 1'b0;
		is_cont = (byte_value[7:6] == 2'b10);

		if (pcnt_q == 2'd0) begin
			start = 1'b1;
		end else if (is_cont) begin
			if (({1'b0, pcnt_q} + 3'd1) >= slen_q) begin
				has_cp = 1'b1;
				cp     = acc[u8g_pkg::CP_W-1:0];
				pcnt_n = 2'd0;
				slen_n = 3'd0;
			end else if (pcnt_q != 2'd3) begin
				pend_n[pcnt_q] = byte_value;
				pcnt_n         = pcnt_q + 2'd1;
			end
		end else begin
			// broken sequence: one '?' per buffered byte, then decode afresh
			rep    = {1'b0, pcnt_q};
			pcnt_n = 2'd0;
			slen_n = 3'd0;
			start  = 1'b1;
		end

		if (start) begin
			if (!byte_value[7]) begin
				has_cp = 1'b1;
				cp     = {{(u8g_pkg::CP_W-u8g_pkg::BYTE_W){1'b0}}, byte_value};
			end else if (lead_len == 3'd0) begin
				rep = rep + 3'd1;
			end else begin
				pend_n[0] = byte_value;
				pcnt_n    = 2'd1;
				slen_n    = lead_len;
			end
		end

		if (string_end && pcnt_n != 2'd0) begin
			rep    = rep + {1'b0, pcnt_n};
			pcnt_n = 2'd0;
			slen_n = 3'd0;
		end
	end

	assign job_valid    = accept && (rep != 3'd0 || has_cp);
	assign job.rep_cnt  = rep;
	assign job.has_cp   = has_cp;
	assign job.cp       = cp;
	assign job.text_end = string_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q[0] <= '0;
			pend_q[1] <= '0;
			pend_q[2] <= '0;
			pcnt_q    <= 2'd0;
			slen_q    <= 3'd0;
		end else if (accept) begin
			pend_q <= pend_n;
			pcnt_q <= pcnt_n;
			slen_q <= slen_n;
		end
	end

endmodule

// ----- rtl/u8g_job_fifo.sv -----
// Short job queue between the decoder and the result sequencer.
module u8g_job_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  u8g_pkg::job_t wr_job,
	output logic          full,
	input  logic          rd_en,
	output u8g_pkg::job_t rd_job,
	output logic          not_empty
);

	u8g_pkg::job_t                 mem_q [u8g_pkg::JOB_DEPTH];
	logic [u8g_pkg::JOB_PTR_W-1:0] wr_ptr_q;
	logic [u8g_pkg::JOB_PTR_W-1:0] rd_ptr_q;
	logic [u8g_pkg::JOB_CNT_W-1:0] cnt_q;
	logic                          do_wr;
	logic                          do_rd;

	assign full      = (cnt_q == u8g_pkg::JOB_CNT_W'(u8g_pkg::JOB_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign do_wr     = wr_en && !full;
	assign do_rd     = rd_en && not_empty;
	assign rd_job    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + u8g_pkg::JOB_PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + u8g_pkg::JOB_PTR_W'(1);
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + u8g_pkg::JOB_CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - u8g_pkg::JOB_CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- rtl/u8g_back.sv -----
// Result sequencer: expands jobs into results, maps glyphs, holds the output register.
module u8g_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  u8g_pkg::font_cfg_t         cfg,
	input  logic                       job_valid,
	input  u8g_pkg::job_t              job,
	output logic                       job_pop,
	input  logic                       pop,
	output logic                       empty,
	output logic [u8g_pkg::CP_W-1:0]   code_point,
	output logic                       is_replacement,
	output logic [u8g_pkg::CODE_W-1:0] glyph_index,
	output logic                       has_glyph,
	output logic                       run_last,
	output logic                       text_last
);

	logic [2:0]                 idx_q;
	logic                       out_valid_q;
	logic [u8g_pkg::CP_W-1:0]   cp_q;
	logic                       repl_q;
	logic [u8g_pkg::CODE_W-1:0] glyph_q;
	logic                       has_q;
	logic                       run_last_q;
	logic                       text_last_q;

	logic                       advance;
	logic [2:0]                 total;
	logic                       item_last;
	logic                       item_repl;
	logic [u8g_pkg::CP_W-1:0]   item_cp;
	logic                       in_rng;
	logic                       fb_in_rng;
	logic [u8g_pkg::CODE_W-1:0] look;
	logic                       item_has;
	logic [u8g_pkg::CODE_W-1:0] item_glyph;

	assign total     = job.rep_cnt + {2'b0, job.has_cp};
	assign item_last = (idx_q == total - 3'd1);
	assign item_repl = (idx_q < job.rep_cnt);
	assign item_cp   = item_repl ? u8g_pkg::FALLBACK_CP : job.cp;
	assign advance   = job_valid && (!out_valid_q || pop);
	assign job_pop   = advance && item_last;

	always_comb begin
		in_rng = (item_cp >= {5'b0, cfg.first_code}) && (item_cp <= {5'b0, cfg.last_code});
		fb_in_rng = (u8g_pkg::FALLBACK_CP >= {5'b0, cfg.first_code})
			&& (u8g_pkg::FALLBACK_CP <= {5'b0, cfg.last_code});
		look = in_rng ? item_cp[u8g_pkg::CODE_W-1:0]
			: u8g_pkg::FALLBACK_CP[u8g_pkg::CODE_W-1:0];
		item_has   = in_rng || fb_in_rng;
		item_glyph = item_has ? (look - cfg.first_code) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				idx_q       <= item_last ? 3'd0 : idx_q + 3'd1;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cp_q        <= item_cp;
			repl_q      <= item_repl;
			glyph_q     <= item_glyph;
			has_q       <= item_has;
			run_last_q  <= item_last;
			text_last_q <= item_last && job.text_end;
		end
	end

	assign empty          = !out_valid_q;
	assign code_point     = cp_q;
	assign is_replacement = repl_q;
	assign glyph_index    = glyph_q;
	assign has_glyph      = has_q;
	assign run_last       = run_last_q;
	assign text_last      = text_last_q;

	// a held result must not let the sequencer move on within its job
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !pop) |=> (out_valid_q && $stable(idx_q)))
		else $error("sequencer advanced while result was held");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && text_last_q) |-> run_last_q)
		else $error("end of string not on last result of its byte");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && repl_q) |-> (cp_q == u8g_pkg::FALLBACK_CP))
		else $error("replacement result without fallback codepoint");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !has_q) |-> (glyph_q == '0))
		else $error("glyph index set with no glyph");

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the UTF-8 to glyph index unit.
module tb;
	import u8g_pkg::*;

	localparam int LIMIT_CYCLES   = 400000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int WINDOW_COUNT   = 9;
	localparam int STREAM_BYTES   = 480;
	localparam int REPORT_LIMIT   = 10;

	typedef struct packed {
		logic [CP_W-1:0]   cp;
		logic              repl;
		logic [CODE_W-1:0] glyph;
		logic              has;
		logic              run_end;
		logic              text_end;
	} glyph_res_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 push = 1'b0;
	logic                 full;
	logic [BYTE_W-1:0]    byte_value = '0;
	logic                 string_end = 1'b0;
	logic                 empty;
	logic                 pop = 1'b0;
	logic [CP_W-1:0]      code_point;
	logic                 is_replacement;
	logic [CODE_W-1:0]    glyph_index;
	logic                 has_glyph;
	logic                 run_last;
	logic                 text_last;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CODE_W-1:0]    cfg_data = '0;

	// decoder shadow state and font window
	logic [BYTE_W-1:0] held [3];
	int unsigned       held_cnt = 0;
	int unsigned       seq_len = 0;
	logic [CODE_W-1:0] font_first = FIRST_CODE_RST;
	logic [CODE_W-1:0] font_last = LAST_CODE_RST;

	glyph_res_t  glyph_q [$];
	glyph_res_t  step_q [$];
	int unsigned mismatch_cnt = 0;
	int unsigned bytes_sent = 0;
	int unsigned cycle_cnt = 0;
	int unsigned send_gap_pct = 27;
	int unsigned pop_gap_pct = 72;

	utf8_to_glyph_index_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.byte_value(byte_value),
		.string_end(string_end),
		.empty(empty),
		.pop(pop),
		.code_point(code_point),
		.is_replacement(is_replacement),
		.glyph_index(glyph_index),
		.has_glyph(has_glyph),
		.run_last(run_last),
		.text_last(text_last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// ---------------- glyph prediction ----------------

	function automatic void add_glyph(input logic [CP_W-1:0] cp, input logic repl);
		glyph_res_t  r;
		int unsigned look;
		look = cp;
		r = '0;
		r.cp = cp;
		r.repl = repl;
		// out-of-window codepoints fall back to '?', which may be missing too
		if (look < font_first || look > font_last)
			look = FALLBACK_CP;
		if (look >= font_first && look <= font_last) begin
			r.has = 1'b1;
			r.glyph = CODE_W'(look - font_first);
		end
		step_q.push_back(r);
	endfunction

	function automatic void clear_held();
		held[0] = '0;
		held[1] = '0;
		held[2] = '0;
		held_cnt = 0;
		seq_len = 0;
	endfunction

	function automatic void flush_held();
		for (int unsigned i = 0; i < held_cnt; i++)
			add_glyph(FALLBACK_CP, 1'b1);
		clear_held();
	endfunction

	function automatic void start_seq(input logic [BYTE_W-1:0] b);
		int unsigned len;
		len = 0;
		if (!b[7]) begin
			add_glyph(CP_W'(b), 1'b0);
			return;
		end
		if (b[7:5] == 3'b110)
			len = 2;
		else if (b[7:4] == 4'b1110)
			len = 3;
		else if (b[7:3] == 5'b11110)
			len = 4;
		if (len == 0) begin
			add_glyph(FALLBACK_CP, 1'b1);
			return;
		end
		held[0] = b;
		held_cnt = 1;
		seq_len = len;
	endfunction

	function automatic logic [CP_W-1:0] join_seq(input logic [BYTE_W-1:0] b);
		logic [31:0] acc;
		if (seq_len == 2)
			acc = {27'd0, held[0][4:0]};
		else if (seq_len == 3)
			acc = {28'd0, held[0][3:0]};
		else
			acc = {29'd0, held[0][2:0]};
		for (int unsigned i = 1; i < held_cnt; i++)
			acc = (acc << 6) | {26'd0, held[i][5:0]};
		acc = (acc << 6) | {26'd0, b[5:0]};
		return acc[CP_W-1:0];
	endfunction

	// expected results of one accepted byte, appended to glyph_q
	function automatic void decode_byte(input logic [BYTE_W-1:0] b, input logic e);
		glyph_res_t r;
		step_q.delete();
		if (held_cnt == 0) begin
			start_seq(b);
		end else if (b[7:6] == 2'b10) begin
			if (held_cnt + 1 >= seq_len) begin
				add_glyph(join_seq(b), 1'b0);
				clear_held();
			end else if (held_cnt < 3) begin
				held[held_cnt] = b;
				held_cnt++;
			end
		end else begin
			flush_held();
			start_seq(b);
		end
		if (e && held_cnt != 0)
			flush_held();
		if (step_q.size() > 0) begin
			r = step_q[step_q.size()-1];
			r.run_end = 1'b1;
			r.text_end = e;
			step_q[step_q.size()-1] = r;
		end
		foreach (step_q[i])
			glyph_q.push_back(step_q[i]);
	endfunction

	// ---------------- result checking ----------------

	function automatic string fmt_res(input glyph_res_t r);
		return $sformatf("cp=%0h repl=%0b glyph=%0h has=%0b run_last=%0b text_last=%0b",
			r.cp, r.repl, r.glyph, r.has, r.run_end, r.text_end);
	endfunction

	always @(posedge clk) begin
		glyph_res_t got;
		glyph_res_t want;
		if (arst_n && pop && !empty) begin
			got = {code_point, is_replacement, glyph_index, has_glyph, run_last, text_last};
			if (glyph_q.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= REPORT_LIMIT)
					$display("unexpected result: %s", fmt_res(got));
			end else begin
				want = glyph_q.pop_front();
				if (got !== want) begin
					mismatch_cnt++;
					if (mismatch_cnt <= REPORT_LIMIT)
						$display("mismatch: expected %s, got %s", fmt_res(want),
							fmt_res(got));
				end
			end
		end
		pop <= ($urandom_range(99) >= pop_gap_pct);
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ---------------- stimulus ----------------

	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic e);
		while ($urandom_range(99) < send_gap_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		byte_value <= b;
		string_end <= e;
		do @(posedge clk); while (full);
		decode_byte(b, e);
		bytes_sent++;
	endtask

	task automatic hold_until_drained();
		push <= 1'b0;
		do @(posedge clk); while (glyph_q.size() != 0);
	endtask

	// drained plus a few cycles for a byte that produced nothing yet
	task automatic settle_idle();
		hold_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_font(input logic [CODE_W-1:0] first, input logic [CODE_W-1:0] last);
		settle_idle();
		cfg_valid <= 1'b1;
		cfg_index <= CFG_FIRST_CODE;
		cfg_data <= first;
		do @(posedge clk); while (!cfg_ready);
		font_first = first;
		cfg_index <= CFG_LAST_CODE;
		cfg_data <= last;
		do @(posedge clk); while (!cfg_ready);
		font_last = last;
		cfg_valid <= 1'b0;
	endtask

	// mostly well-formed characters, some cut short, some raw noise bytes
	task automatic send_random_char();
		int unsigned       kind;
		int unsigned       len;
		int unsigned       n;
		logic [BYTE_W-1:0] seq [4];
		kind = $urandom_range(99);
		len = $urandom_range(1, 4);
		case (len)
			1: seq[0] = BYTE_W'($urandom_range(127));
			2: seq[0] = 8'hC0 | BYTE_W'($urandom_range(31));
			3: seq[0] = 8'hE0 | BYTE_W'($urandom_range(15));
			default: seq[0] = 8'hF0 | BYTE_W'($urandom_range(7));
		endcase
		for (int i = 1; i < 4; i++)
			seq[i] = 8'h80 | BYTE_W'($urandom_range(63));
		n = len;
		if (kind >= 85) begin
			seq[0] = BYTE_W'($urandom_range(255));
			n = 1;
		end else if (kind >= 65 && len > 1) begin
			n = $urandom_range(1, len - 1);
		end
		for (int unsigned i = 0; i < n; i++)
			send_byte(seq[i], $urandom_range(15) == 0);
	endtask

	// ---------------- tests ----------------

	task automatic test_decode_cases();
		send_byte(8'h41, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h7F, 1'b0);         // outside reset window, '?' stands in
		send_byte(8'hC3, 1'b0);
		send_byte(8'hA9, 1'b0);
		send_byte(8'hE2, 1'b0);
		send_byte(8'h82, 1'b0);
		send_byte(8'hAC, 1'b0);
		send_byte(8'hF0, 1'b0);
		send_byte(8'h9F, 1'b0);
		send_byte(8'h98, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h80, 1'b0);         // lone continuation
		send_byte(8'hF8, 1'b0);         // invalid lead
		send_byte(8'hE2, 1'b0);
		send_byte(8'h82, 1'b0);
		send_byte(8'h41, 1'b1);         // broken sequence, then string end
		send_byte(8'hF0, 1'b0);
		send_byte(8'h9F, 1'b1);         // string ends mid-sequence
	endtask

	task automatic test_font_edges();
		set_font(16'd0, 16'd0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h41, 1'b1);
		set_font(16'd100, 16'd50);      // empty window
		send_byte(8'h3F, 1'b1);
		set_font(16'hFFFF, 16'hFFFF);
		send_byte(8'hEF, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'h41, 1'b1);
	endtask

	task automatic test_random_stream();
		int unsigned       window_end;
		int unsigned       mid;
		logic [CODE_W-1:0] first;
		logic [CODE_W-1:0] last;
		window_end = bytes_sent;
		for (int w = 0; w < WINDOW_COUNT; w++) begin
			case (w / 3)
				0: begin
					send_gap_pct = 27;
					pop_gap_pct = 72;
				end
				1: begin
					send_gap_pct = 72;
					pop_gap_pct = 27;
				end
				default: begin
					send_gap_pct = 0;
					pop_gap_pct = 0;
				end
			endcase
			first = CODE_W'($urandom_range(255));
			last = CODE_W'($urandom_range(first, 65535));
			case (w)
				0: set_font(FIRST_CODE_RST, LAST_CODE_RST);
				1: set_font(16'd0, 16'hFFFF);
				3: set_font(16'hFFFF, 16'd0);
				4: set_font(16'd0, 16'd0);
				5: set_font(16'hFFFF, 16'hFFFF);
				7: set_font(16'd64, 16'd200);   // '?' itself has no glyph
				default: set_font(first, last);
			endcase
			mid = window_end + STREAM_BYTES / (2 * WINDOW_COUNT);
			window_end += STREAM_BYTES / WINDOW_COUNT;
			while (bytes_sent < mid)
				send_random_char();
			hold_until_drained();
			while (bytes_sent < window_end)
				send_random_char();
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_decode_cases();
		test_font_edges();
		test_random_stream();
		settle_idle();
		if (mismatch_cnt == 0 && glyph_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/u8g_pkg.sv
rtl/u8g_front.sv
rtl/u8g_job_fifo.sv
rtl/u8g_back.sv
rtl/utf8_to_glyph_index_unit.sv
tb/sv/tb.sv
